FILE: rtl/plsf_pkg.sv
// Shared types, constants and saturating arithmetic helpers for the polynomial fitter.
`default_nettype none

package plsf_pkg;

    localparam int ROW_W = 3;
    localparam int COL_W = 4;

    localparam logic signed [63:0] Q_ONE = 64'sh0000_0001_0000_0000;
    localparam logic signed [63:0] Q_MAX = 64'sh7FFF_FFFF_FFFF_FFFF;
    localparam logic signed [63:0] Q_MIN = 64'sh8000_0000_0000_0000;

    typedef struct packed {
        logic signed [15:0] measured_sample;
        logic signed [15:0] expected_sample;
        logic               final_point;
    } plsf_in_t;

    typedef struct packed {
        logic [2:0]         coeff_index;
        logic signed [63:0] coeff_value;
        logic               singular;
        logic               last_coeff;
    } plsf_out_t;

    typedef enum logic [4:0] {
        OP_NOP,
        OP_LOAD_IN,
        OP_ACC_SUM,
        OP_MUL_PY,
        OP_MUL_PX,
        OP_ACC_W,
        OP_SET_P,
        OP_CLEAR,
        OP_CLR_SING,
        OP_FILL,
        OP_LD_T,
        OP_LD_D,
        OP_WR_RDATA,
        OP_WR_T,
        OP_DIV_RD,
        OP_SET_F,
        OP_MUL_RF,
        OP_WR_SUB,
        OP_WR_DIV,
        OP_CLR_V,
        OP_MUL_RW,
        OP_ACC_V,
        OP_EMIT
    } plsf_op_t;

    typedef struct packed {
        plsf_op_t           op;
        logic               rd_en;
        logic [ROW_W-1:0]   rd_row;
        logic [COL_W-1:0]   rd_col;
        logic [ROW_W-1:0]   wr_row;
        logic [COL_W-1:0]   wr_col;
        logic [COL_W-1:0]   idx;
    } plsf_cmd_t;

    typedef struct packed {
        logic mul_done;
        logic div_done;
        logic swap_lt;
        logic out_free;
    } plsf_stat_t;

    typedef enum logic [5:0] {
        S_IDLE,
        S_ACC_SUM,
        S_ACC_MUL,
        S_ACC_MYW,
        S_ACC_PX,
        S_ACC_MXW,
        S_FILL_INIT,
        S_FILL,
        S_SW_RD0,
        S_SW_RD1,
        S_SW_CMP,
        S_SW_A,
        S_SW_B,
        S_SW_C,
        S_SW_D,
        S_EL_RDD,
        S_EL_RDT,
        S_EL_DIV,
        S_EL_DIVW,
        S_EL_RDC,
        S_EL_MUL,
        S_EL_MULW,
        S_EL_WR,
        S_NM_RDD,
        S_NM_LDD,
        S_NM_RD,
        S_NM_DIV,
        S_NM_DIVW,
        S_OT_CLR,
        S_OT_RD,
        S_OT_MUL,
        S_OT_MULW,
        S_OT_EMIT,
        S_CLEAR
    } plsf_state_t;

    function automatic logic [63:0] mag_of(input logic signed [63:0] v);
        mag_of = v[63] ? (~v + 64'd1) : v;
    endfunction

    function automatic logic signed [63:0] from_mag(input logic [63:0] mag,
                                                    input logic neg,
                                                    input logic ovf);
        if (neg) begin
            from_mag = (ovf || mag[63]) ? Q_MIN : -$signed(mag);
        end else begin
            from_mag = (ovf || mag[63]) ? Q_MAX : $signed(mag);
        end
    endfunction

    function automatic logic signed [63:0] sat_add(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s[64] != s[63]) begin
            sat_add = s[64] ? Q_MIN : Q_MAX;
        end else begin
            sat_add = s[63:0];
        end
    endfunction

    function automatic logic signed [63:0] sat_sub(input logic signed [63:0] a,
                                                   input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s[64] != s[63]) begin
            sat_sub = s[64] ? Q_MIN : Q_MAX;
        end else begin
            sat_sub = s[63:0];
        end
    endfunction

endpackage

`default_nettype wire

FILE: rtl/plsf_mul.sv
// Multi-cycle Q32.32 multiplier: four 32x32 partial products, then round and saturate.
`default_nettype none

module plsf_mul
    import plsf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic               busy,
    output logic               done,
    output logic signed [63:0] res
);

    logic [63:0]  ua_reg, ub_reg;
    logic         neg_reg;
    logic [127:0] acc_reg;
    logic [2:0]   step_reg;
    logic         busy_reg, done_reg;
    logic signed [63:0] res_reg;

    logic [31:0]  a_half, b_half;
    logic [63:0]  pp;
    logic [127:0] pp_sh;
    logic [127:0] rnd;

    always_comb begin
        a_half = step_reg[1] ? ua_reg[63:32] : ua_reg[31:0];
        b_half = step_reg[0] ? ub_reg[63:32] : ub_reg[31:0];
        pp     = a_half * b_half;
        unique case (step_reg[1:0])
            2'b00:         pp_sh = {64'd0, pp};
            2'b01, 2'b10:  pp_sh = {32'd0, pp, 32'd0};
            default:       pp_sh = {pp, 64'd0};
        endcase
        rnd = acc_reg + 128'h8000_0000;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            step_reg <= 3'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= 1'b1;
                step_reg <= 3'd0;
            end else if (busy_reg) begin
                if (step_reg == 3'd4) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    step_reg <= step_reg + 3'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            ua_reg  <= mag_of(a);
            ub_reg  <= mag_of(b);
            neg_reg <= a[63] ^ b[63];
            acc_reg <= '0;
        end else if (busy_reg) begin
            if (step_reg == 3'd4) begin
                res_reg <= from_mag(rnd[95:32], neg_reg, |rnd[127:96]);
            end else begin
                acc_reg <= acc_reg + pp_sh;
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

FILE: rtl/plsf_div.sv
// Bit-serial Q32.32 divider: one quotient bit a cycle, then round and saturate.
`default_nettype none

module plsf_div
    import plsf_pkg::*;
(
    input  logic               aclk,
    input  logic               aresetn,
    input  logic               start,
    input  logic signed [63:0] a,
    input  logic signed [63:0] b,
    output logic               busy,
    output logic               done,
    output logic signed [63:0] res
);

    localparam logic [6:0] NUM_BITS = 7'd96;

    logic [95:0] num_reg;
    logic [63:0] ub_reg, rem_reg, q_reg;
    logic        neg_reg, ovf_reg;
    logic [6:0]  cnt_reg;
    logic        busy_reg, done_reg;
    logic signed [63:0] res_reg;

    logic [64:0] rem_sh;
    logic        ge;
    logic [64:0] q_inc;
    logic        rnd_up;

    always_comb begin
        rem_sh = {rem_reg, num_reg[95]};
        ge     = rem_sh >= {1'b0, ub_reg};
        rnd_up = rem_reg >= (ub_reg - rem_reg);
        q_inc  = {1'b0, q_reg} + 65'd1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= 7'd0;
        end else begin
            done_reg <= 1'b0;
            if (start) begin
                busy_reg <= (b != 64'sd0);
                done_reg <= (b == 64'sd0);
                cnt_reg  <= 7'd0;
            end else if (busy_reg) begin
                if (cnt_reg == NUM_BITS) begin
                    busy_reg <= 1'b0;
                    done_reg <= 1'b1;
                end else begin
                    cnt_reg <= cnt_reg + 7'd1;
                end
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            num_reg <= {mag_of(a), 32'd0};
            ub_reg  <= mag_of(b);
            neg_reg <= a[63] ^ b[63];
            rem_reg <= '0;
            q_reg   <= '0;
            ovf_reg <= 1'b0;
            if (b == 64'sd0) begin
                res_reg <= '0;
            end
        end else if (busy_reg) begin
            if (cnt_reg == NUM_BITS) begin
                if (rnd_up) begin
                    res_reg <= from_mag(q_inc[63:0], neg_reg, ovf_reg | q_inc[64]);
                end else begin
                    res_reg <= from_mag(q_reg, neg_reg, ovf_reg);
                end
            end else begin
                num_reg <= {num_reg[94:0], 1'b0};
                rem_reg <= ge ? (rem_sh[63:0] - ub_reg) : rem_sh[63:0];
                q_reg   <= {q_reg[62:0], ge};
                ovf_reg <= ovf_reg | q_reg[63];
            end
        end
    end

    assign busy = busy_reg;
    assign done = done_reg;
    assign res  = res_reg;

endmodule

`default_nettype wire

FILE: rtl/plsf_datapath.sv
// Datapath: sums, matrix memory, work registers, arithmetic units and result register.
`default_nettype none

module plsf_datapath
    import plsf_pkg::*;
#(
    parameter int NUM_COEFFS = 4
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  plsf_cmd_t  cmd,
    output plsf_stat_t stat,
    input  plsf_in_t   s_data,
    output logic       m_valid,
    input  logic       m_ready,
    output plsf_out_t  m_data
);

    localparam int NSUMS = 2 * NUM_COEFFS - 1;
    localparam int RW    = $clog2(NUM_COEFFS);
    localparam int CW    = $clog2(2 * NUM_COEFFS);
    localparam int SW    = $clog2(NSUMS);
    localparam int DEPTH = 2 ** (RW + CW);

    logic signed [63:0] sum_reg [NSUMS];
    logic signed [63:0] wsum_reg [NUM_COEFFS];
    logic signed [63:0] mat_mem [DEPTH];

    logic signed [63:0] x_reg, y_reg, p_reg, t_reg, d_reg, f_reg, v_reg, rdata_reg;
    logic               sing_reg;
    logic               m_valid_reg;
    plsf_out_t          m_data_reg;

    logic               mul_start, div_start, mul_busy, div_busy, mul_done, div_done;
    logic signed [63:0] mul_a, mul_b, mul_res, div_res;
    logic               wr_en;
    logic signed [63:0] wr_data;
    logic [RW+CW-1:0]   rd_addr, wr_addr;
    logic [COL_W:0]     fill_sum;
    logic signed [63:0] fill_val;
    logic [SW-1:0]      sidx;
    logic [RW-1:0]      widx;

    always_comb begin
        rd_addr  = {cmd.rd_row[RW-1:0], cmd.rd_col[CW-1:0]};
        wr_addr  = {cmd.wr_row[RW-1:0], cmd.wr_col[CW-1:0]};
        sidx     = cmd.idx[SW-1:0];
        widx     = cmd.idx[RW-1:0];
        fill_sum = {1'b0, cmd.wr_col} + (COL_W+1)'(cmd.wr_row);
        if (cmd.wr_col < COL_W'(NUM_COEFFS)) begin
            fill_val = sum_reg[fill_sum[SW-1:0]];
        end else if (cmd.wr_col - COL_W'(NUM_COEFFS) == COL_W'(cmd.wr_row)) begin
            fill_val = Q_ONE;
        end else begin
            fill_val = '0;
        end

        mul_start = 1'b0;
        mul_a     = rdata_reg;
        mul_b     = f_reg;
        unique case (cmd.op)
            OP_MUL_PY: begin
                mul_start = 1'b1;
                mul_a     = p_reg;
                mul_b     = y_reg;
            end
            OP_MUL_PX: begin
                mul_start = 1'b1;
                mul_a     = p_reg;
                mul_b     = x_reg;
            end
            OP_MUL_RF: begin
                mul_start = 1'b1;
            end
            OP_MUL_RW: begin
                mul_start = 1'b1;
                mul_b     = wsum_reg[widx];
            end
            default: begin
                mul_start = 1'b0;
            end
        endcase
        div_start = (cmd.op == OP_DIV_RD);

        wr_en   = 1'b1;
        wr_data = rdata_reg;
        unique case (cmd.op)
            OP_FILL:     wr_data = fill_val;
            OP_WR_RDATA: wr_data = rdata_reg;
            OP_WR_T:     wr_data = t_reg;
            OP_WR_SUB:   wr_data = sat_sub(rdata_reg, mul_res);
            OP_WR_DIV:   wr_data = div_res;
            default:     wr_en   = 1'b0;
        endcase
    end

    plsf_mul u_mul (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (mul_start),
        .a       (mul_a),
        .b       (mul_b),
        .busy    (mul_busy),
        .done    (mul_done),
        .res     (mul_res)
    );

    plsf_div u_div (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (div_start),
        .a       (rdata_reg),
        .b       (d_reg),
        .busy    (div_busy),
        .done    (div_done),
        .res     (div_res)
    );

    // matrix work area
    always_ff @(posedge aclk) begin
        if (wr_en) begin
            mat_mem[wr_addr] <= wr_data;
        end
        if (cmd.rd_en) begin
            rdata_reg <= mat_mem[rd_addr];
        end
    end

    // sums, flags and result valid
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int i = 0; i < NSUMS; i++) begin
                sum_reg[i] <= '0;
            end
            for (int i = 0; i < NUM_COEFFS; i++) begin
                wsum_reg[i] <= '0;
            end
            sing_reg    <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            if (cmd.op == OP_EMIT) begin
                m_valid_reg <= 1'b1;
            end else if (m_ready) begin
                m_valid_reg <= 1'b0;
            end
            unique case (cmd.op)
                OP_ACC_SUM:  sum_reg[sidx] <= sat_add(sum_reg[sidx], p_reg);
                OP_ACC_W:    wsum_reg[widx] <= sat_add(wsum_reg[widx], mul_res);
                OP_CLR_SING: sing_reg <= 1'b0;
                OP_DIV_RD: begin
                    if (d_reg == 64'sd0) begin
                        sing_reg <= 1'b1;
                    end
                end
                OP_CLEAR: begin
                    for (int i = 0; i < NSUMS; i++) begin
                        sum_reg[i] <= '0;
                    end
                    for (int i = 0; i < NUM_COEFFS; i++) begin
                        wsum_reg[i] <= '0;
                    end
                end
                default: ;
            endcase
        end
    end

    // work registers and result data
    always_ff @(posedge aclk) begin
        unique case (cmd.op)
            OP_LOAD_IN: begin
                x_reg <= {{29{s_data.measured_sample[15]}}, s_data.measured_sample, 19'd0};
                y_reg <= {{29{s_data.expected_sample[15]}}, s_data.expected_sample, 19'd0};
                p_reg <= Q_ONE;
            end
            OP_SET_P: p_reg <= mul_res;
            OP_LD_T:  t_reg <= rdata_reg;
            OP_LD_D:  d_reg <= rdata_reg;
            OP_SET_F: f_reg <= div_res;
            OP_CLR_V: v_reg <= '0;
            OP_ACC_V: v_reg <= sat_add(v_reg, mul_res);
            OP_EMIT: begin
                m_data_reg.coeff_index <= 3'(cmd.wr_row);
                m_data_reg.coeff_value <= v_reg;
                m_data_reg.singular    <= sing_reg;
                m_data_reg.last_coeff  <= (cmd.wr_row == ROW_W'(NUM_COEFFS - 1));
            end
            default: ;
        endcase
    end

    assign stat.mul_done = mul_done;
    assign stat.div_done = div_done;
    assign stat.swap_lt  = (t_reg < rdata_reg);
    assign stat.out_free = !m_valid_reg || m_ready;
    assign m_valid       = m_valid_reg;
    assign m_data        = m_data_reg;

    a_emit_free: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_EMIT |-> (!m_valid_reg || m_ready))
        else $error("result overwritten while stalled");
    a_emit_valid: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_EMIT |=> m_valid_reg)
        else $error("emitted result not presented");
    a_mul_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        mul_start |-> !mul_busy)
        else $error("multiplier restarted while busy");
    a_div_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        div_start |-> !div_busy)
        else $error("divider restarted while busy");

endmodule

`default_nettype wire

FILE: rtl/plsf_ctrl.sv
// Controller: sequences accumulation, matrix fill, reorder, elimination, normalisation, output and clear.
`default_nettype none

module plsf_ctrl
    import plsf_pkg::*;
#(
    parameter int NUM_COEFFS = 4,
    parameter int MAX_POINTS = 64
) (
    input  logic       aclk,
    input  logic       aresetn,
    input  logic       s_valid,
    input  logic       s_final,
    output logic       s_ready,
    input  plsf_stat_t stat,
    output plsf_cmd_t  cmd
);

    localparam int              CNT_W    = $clog2(MAX_POINTS + 1);
    localparam logic [CNT_W-1:0] CNT_MAX = CNT_W'(MAX_POINTS);
    localparam logic [ROW_W-1:0] LAST_ROW = ROW_W'(NUM_COEFFS - 1);
    localparam logic [COL_W-1:0] LAST_COL = COL_W'(2 * NUM_COEFFS - 1);
    localparam logic [COL_W-1:0] LAST_SUM = COL_W'(2 * NUM_COEFFS - 2);
    localparam logic [COL_W-1:0] NCOEF_C  = COL_W'(NUM_COEFFS);

    plsf_state_t       state_reg, state_next;
    logic [ROW_W-1:0]  r_reg, r_next, k_reg, k_next;
    logic [COL_W-1:0]  c_reg, c_next;
    logic [CNT_W-1:0]  cnt_reg, cnt_next;
    logic              final_reg, final_next;
    logic [ROW_W:0]    nr1, nr;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= S_IDLE;
            r_reg     <= '0;
            k_reg     <= '0;
            c_reg     <= '0;
            cnt_reg   <= '0;
            final_reg <= 1'b0;
        end else begin
            state_reg <= state_next;
            r_reg     <= r_next;
            k_reg     <= k_next;
            c_reg     <= c_next;
            cnt_reg   <= cnt_next;
            final_reg <= final_next;
        end
    end

    always_comb begin
        // next elimination row, skipping the pivot row
        nr1 = {1'b0, r_reg} + 1'b1;
        nr  = (nr1 == {1'b0, k_reg}) ? nr1 + 1'b1 : nr1;

        state_next = state_reg;
        r_next     = r_reg;
        k_next     = k_reg;
        c_next     = c_reg;
        cnt_next   = cnt_reg;
        final_next = final_reg;
        s_ready    = 1'b0;
        cmd        = '{op: OP_NOP, rd_en: 1'b0, rd_row: r_reg, rd_col: c_reg,
                       wr_row: r_reg, wr_col: c_reg, idx: c_reg};

        unique case (state_reg)
            S_IDLE: begin
                s_ready = 1'b1;
                if (s_valid) begin
                    cmd.op     = OP_LOAD_IN;
                    final_next = s_final;
                    c_next     = '0;
                    if (cnt_reg < CNT_MAX) begin
                        cnt_next   = cnt_reg + 1'b1;
                        state_next = S_ACC_SUM;
                    end else if (s_final) begin
                        state_next = S_FILL_INIT;
                    end
                end
            end
            S_ACC_SUM: begin
                cmd.op     = OP_ACC_SUM;
                state_next = S_ACC_MUL;
            end
            S_ACC_MUL: begin
                if (c_reg < NCOEF_C) begin
                    cmd.op     = OP_MUL_PY;
                    state_next = S_ACC_MYW;
                end else begin
                    cmd.op     = OP_MUL_PX;
                    state_next = S_ACC_MXW;
                end
            end
            S_ACC_MYW: begin
                if (stat.mul_done) begin
                    cmd.op     = OP_ACC_W;
                    state_next = S_ACC_PX;
                end
            end
            S_ACC_PX: begin
                cmd.op     = OP_MUL_PX;
                state_next = S_ACC_MXW;
            end
            S_ACC_MXW: begin
                if (stat.mul_done) begin
                    cmd.op = OP_SET_P;
                    if (c_reg == LAST_SUM) begin
                        state_next = final_reg ? S_FILL_INIT : S_IDLE;
                    end else begin
                        c_next     = c_reg + 1'b1;
                        state_next = S_ACC_SUM;
                    end
                end
            end
            S_FILL_INIT: begin
                cmd.op     = OP_CLR_SING;
                r_next     = '0;
                c_next     = '0;
                state_next = S_FILL;
            end
            S_FILL: begin
                cmd.op = OP_FILL;
                if (c_reg == LAST_COL) begin
                    c_next = '0;
                    if (r_reg == LAST_ROW) begin
                        state_next = S_SW_RD0;
                    end else begin
                        r_next = r_reg + 1'b1;
                    end
                end else begin
                    c_next = c_reg + 1'b1;
                end
            end
            S_SW_RD0: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_row = r_reg - 1'b1;
                cmd.rd_col = '0;
                state_next = S_SW_RD1;
            end
            S_SW_RD1: begin
                cmd.op     = OP_LD_T;
                cmd.rd_en  = 1'b1;
                cmd.rd_col = '0;
                state_next = S_SW_CMP;
            end
            S_SW_CMP: begin
                c_next = '0;
                if (stat.swap_lt) begin
                    state_next = S_SW_A;
                end else if (r_reg == ROW_W'(1)) begin
                    k_next     = '0;
                    r_next     = ROW_W'(1);
                    state_next = S_EL_RDD;
                end else begin
                    r_next     = r_reg - 1'b1;
                    state_next = S_SW_RD0;
                end
            end
            S_SW_A: begin
                cmd.rd_en  = 1'b1;
                state_next = S_SW_B;
            end
            S_SW_B: begin
                cmd.op     = OP_LD_T;
                cmd.rd_en  = 1'b1;
                cmd.rd_row = r_reg - 1'b1;
                state_next = S_SW_C;
            end
            S_SW_C: begin
                cmd.op     = OP_WR_RDATA;
                state_next = S_SW_D;
            end
            S_SW_D: begin
                cmd.op     = OP_WR_T;
                cmd.wr_row = r_reg - 1'b1;
                if (c_reg == LAST_COL) begin
                    c_next = '0;
                    if (r_reg == ROW_W'(1)) begin
                        k_next     = '0;
                        r_next     = ROW_W'(1);
                        state_next = S_EL_RDD;
                    end else begin
                        r_next     = r_reg - 1'b1;
                        state_next = S_SW_RD0;
                    end
                end else begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_SW_A;
                end
            end
            S_EL_RDD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_row = k_reg;
                cmd.rd_col = COL_W'(k_reg);
                state_next = S_EL_RDT;
            end
            S_EL_RDT: begin
                cmd.op     = OP_LD_D;
                cmd.rd_en  = 1'b1;
                cmd.rd_col = COL_W'(k_reg);
                state_next = S_EL_DIV;
            end
            S_EL_DIV: begin
                cmd.op     = OP_DIV_RD;
                state_next = S_EL_DIVW;
            end
            S_EL_DIVW: begin
                if (stat.div_done) begin
                    cmd.op     = OP_SET_F;
                    c_next     = '0;
                    state_next = S_EL_RDC;
                end
            end
            S_EL_RDC: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_row = k_reg;
                state_next = S_EL_MUL;
            end
            S_EL_MUL: begin
                cmd.op     = OP_MUL_RF;
                state_next = S_EL_MULW;
            end
            S_EL_MULW: begin
                if (stat.mul_done) begin
                    cmd.rd_en  = 1'b1;
                    state_next = S_EL_WR;
                end
            end
            S_EL_WR: begin
                cmd.op = OP_WR_SUB;
                if (c_reg == LAST_COL) begin
                    c_next = '0;
                    if (nr > {1'b0, LAST_ROW}) begin
                        if (k_reg == LAST_ROW) begin
                            r_next     = '0;
                            state_next = S_NM_RDD;
                        end else begin
                            k_next     = k_reg + 1'b1;
                            r_next     = '0;
                            state_next = S_EL_RDD;
                        end
                    end else begin
                        r_next     = nr[ROW_W-1:0];
                        state_next = S_EL_RDD;
                    end
                end else begin
                    c_next     = c_reg + 1'b1;
                    state_next = S_EL_RDC;
                end
            end
            S_NM_RDD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_col = COL_W'(r_reg);
                state_next = S_NM_LDD;
            end
            S_NM_LDD: begin
                cmd.op     = OP_LD_D;
                c_next     = '0;
                state_next = S_NM_RD;
            end
            S_NM_RD: begin
                cmd.rd_en  = 1'b1;
                state_next = S_NM_DIV;
            end
            S_NM_DIV: begin
                cmd.op     = OP_DIV_RD;
                state_next = S_NM_DIVW;
            end
            S_NM_DIVW: begin
                if (stat.div_done) begin
                    cmd.op = OP_WR_DIV;
                    if (c_reg == LAST_COL) begin
                        if (r_reg == LAST_ROW) begin
                            r_next     = '0;
                            state_next = S_OT_CLR;
                        end else begin
                            r_next     = r_reg + 1'b1;
                            state_next = S_NM_RDD;
                        end
                    end else begin
                        c_next     = c_reg + 1'b1;
                        state_next = S_NM_RD;
                    end
                end
            end
            S_OT_CLR: begin
                cmd.op     = OP_CLR_V;
                c_next     = '0;
                state_next = S_OT_RD;
            end
            S_OT_RD: begin
                cmd.rd_en  = 1'b1;
                cmd.rd_col = c_reg + NCOEF_C;
                state_next = S_OT_MUL;
            end
            S_OT_MUL: begin
                cmd.op     = OP_MUL_RW;
                state_next = S_OT_MULW;
            end
            S_OT_MULW: begin
                if (stat.mul_done) begin
                    cmd.op = OP_ACC_V;
                    if (c_reg == NCOEF_C - 1'b1) begin
                        state_next = S_OT_EMIT;
                    end else begin
                        c_next     = c_reg + 1'b1;
                        state_next = S_OT_RD;
                    end
                end
            end
            S_OT_EMIT: begin
                if (stat.out_free) begin
                    cmd.op = OP_EMIT;
                    if (r_reg == LAST_ROW) begin
                        state_next = S_CLEAR;
                    end else begin
                        r_next     = r_reg + 1'b1;
                        state_next = S_OT_CLR;
                    end
                end
            end
            S_CLEAR: begin
                cmd.op     = OP_CLEAR;
                cnt_next   = '0;
                state_next = S_IDLE;
            end
            default: begin
                state_next = S_IDLE;
            end
        endcase
    end

    a_cnt_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        cnt_reg <= CNT_MAX)
        else $error("point count beyond limit");
    a_clear_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        state_reg == S_CLEAR |=> state_reg == S_IDLE && cnt_reg == '0)
        else $error("set not closed after clear");
    a_accept_idle: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.op == OP_LOAD_IN |-> s_ready)
        else $error("sample loaded outside accept");

endmodule

`default_nettype wire

FILE: rtl/polynomial_least_squares_fit.sv
// Top level of the polynomial least-squares fitter: controller plus datapath.
//
// Usage: sample pairs (measured, expected, Q2.13) arrive as requests on the s_ channel.
// Each pair is folded into power sums and expected-weighted sums. The pair with
// final_point set closes the set: the Hankel normal equations are built, inverted by
// Gauss-Jordan elimination (one neighbour-swap pass on the first column beforehand)
// and NUM_COEFFS coefficient requests leave on the m_ channel, lowest power first,
// with last_coeff on the final one and singular set on all of them if any zero
// divisor was met. The sums are then cleared for the next set.
// Pairs beyond MAX_POINTS in a set are taken but not accumulated.
// Throughput: one pair at a time; accumulation is paced by the shared multiplier,
// used twice for each of the NUM_COEFFS weighted terms and once for each remaining
// power term. The solve is dominated by the bit-serial divider, which is used
// N*(N-1) + 2*N*N times.
// Reset (aresetn low, synchronous) clears the sums, the count and the controller; the
// matrix work area needs no clearing as it is always filled before use.
// A stalled m_ channel holds the current coefficient in the output register; the
// solve waits before overwriting it, and after the last one new pairs are taken.
`default_nettype none

module polynomial_least_squares_fit
    import plsf_pkg::*;
#(
    parameter int NUM_COEFFS = 4,
    parameter int MAX_POINTS = 64
) (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      s_valid,
    output logic      s_ready,
    input  plsf_in_t  s_data,
    output logic      m_valid,
    input  logic      m_ready,
    output plsf_out_t m_data
);

    plsf_cmd_t  cmd;
    plsf_stat_t stat;

    // sequencer: owns loop counters and point count
    plsf_ctrl #(
        .NUM_COEFFS (NUM_COEFFS),
        .MAX_POINTS (MAX_POINTS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_final (s_data.final_point),
        .s_ready (s_ready),
        .stat    (stat),
        .cmd     (cmd)
    );

    // arithmetic, storage and the result register
    plsf_datapath #(
        .NUM_COEFFS (NUM_COEFFS)
    ) u_datapath (
        .aclk    (aclk),
        .aresetn (aresetn),
        .cmd     (cmd),
        .stat    (stat),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

endmodule

`default_nettype wire

FILE: bench/testbench.sv
// Self-checking bench for the polynomial least-squares fitter: directed and random point sets, own fit model.
`default_nettype none

module testbench;
    import plsf_pkg::*;

    localparam int N_COEF = 4;
    localparam int N_SUMS = 2 * N_COEF - 1;
    localparam int N_COLS = 2 * N_COEF;
    localparam int POINT_CAP = 64;

    // One pending request for the driver: payload, idle cycles before it, and
    // whether the sender must wait for every outstanding coefficient first.
    typedef struct {
        plsf_in_t pair;
        int       gap;
        bit       drain;
    } pair_req_t;

    logic      aclk = 1'b0;
    logic      aresetn = 1'b0;
    logic      s_valid = 1'b0;
    logic      s_ready;
    plsf_in_t  s_data = '0;
    logic      m_valid;
    logic      m_ready = 1'b0;
    plsf_out_t m_data;

    pair_req_t pair_fifo[$];
    plsf_out_t coeff_fifo[$];

    // Fit state mirrored by the bench
    logic signed [63:0] pow_sum [0:N_SUMS-1];
    logic signed [63:0] wgt_sum [0:N_COEF-1];
    int unsigned        set_points;

    int  pairs_total;
    int  pairs_taken;
    int  coeffs_seen;
    int  mismatches;
    int  send_wait;
    int  recv_wait;
    int  hold_left;
    bit  hold_done;
    bit  offer;
    pair_req_t nxt;

    polynomial_least_squares_fit #(
        .NUM_COEFFS(N_COEF),
        .MAX_POINTS(POINT_CAP)
    ) i_dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_valid (s_valid),
        .s_ready (s_ready),
        .s_data  (s_data),
        .m_valid (m_valid),
        .m_ready (m_ready),
        .m_data  (m_data)
    );

    always #5 aclk = ~aclk;

    // ---------------------------------------------------------------
    // Q32.32 arithmetic, saturating
    // ---------------------------------------------------------------
    function automatic logic signed [63:0] fx_pack(input logic [63:0] mag, input bit neg,
                                                   input bit ovf);
        if (neg) begin
            return (ovf || mag[63]) ? Q_MIN : -$signed(mag);
        end else begin
            return (ovf || mag[63]) ? Q_MAX : $signed(mag);
        end
    endfunction

    function automatic logic signed [63:0] fx_add(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} + {b[63], b};
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return Q_MAX;
        if (s < -65'sh0_8000_0000_0000_0000) return Q_MIN;
        return s[63:0];
    endfunction

    function automatic logic signed [63:0] fx_sub(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic signed [64:0] s;
        s = {a[63], a} - {b[63], b};
        if (s > 65'sh0_7FFF_FFFF_FFFF_FFFF) return Q_MAX;
        if (s < -65'sh0_8000_0000_0000_0000) return Q_MIN;
        return s[63:0];
    endfunction

    // Product rounded to nearest, ties away from zero
    function automatic logic signed [63:0] fx_mul(input logic signed [63:0] a,
                                                  input logic signed [63:0] b);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] p;
        ua = a[63] ? (~a + 64'd1) : a;
        ub = b[63] ? (~b + 64'd1) : b;
        p = {64'd0, ua} * {64'd0, ub};
        p = (p + 128'h8000_0000) >> 32;
        return fx_pack(p[63:0], a[63] ^ b[63], |p[127:64]);
    endfunction

    // Quotient a/b in Q32.32, rounded; zero divisor flags the solve as singular
    function automatic logic signed [63:0] fx_div(input logic signed [63:0] a,
                                                  input logic signed [63:0] b,
                                                  inout bit sing);
        logic [63:0]  ua;
        logic [63:0]  ub;
        logic [127:0] num;
        logic [127:0] q;
        logic [127:0] rem;
        if (b == 0) begin
            sing = 1'b1;
            return 64'sd0;
        end
        ua = a[63] ? (~a + 64'd1) : a;
        ub = b[63] ? (~b + 64'd1) : b;
        num = {32'd0, ua, 32'd0};
        q = num / {64'd0, ub};
        rem = num % {64'd0, ub};
        if (rem >= {64'd0, ub} - rem) q = q + 128'd1;
        return fx_pack(q[63:0], a[63] ^ b[63], |q[127:64]);
    endfunction

    function automatic void clear_fit_sums();
        for (int i = 0; i < N_SUMS; i++) pow_sum[i] = '0;
        for (int i = 0; i < N_COEF; i++) wgt_sum[i] = '0;
        set_points = 0;
    endfunction

    // Fold one accepted pair into the sums; on the closing pair solve the
    // normal equations and queue the coefficients.
    function automatic void predict_fit(input plsf_in_t pr);
        logic signed [63:0] xq;
        logic signed [63:0] yq;
        logic signed [63:0] pw;
        logic signed [63:0] f;
        logic signed [63:0] d;
        logic signed [63:0] v;
        logic signed [63:0] t;
        logic signed [63:0] am [0:N_COEF-1][0:N_COLS-1];
        bit sing;
        plsf_out_t res;
        if (set_points < POINT_CAP) begin
            xq = 64'(pr.measured_sample) <<< 19;
            yq = 64'(pr.expected_sample) <<< 19;
            pw = Q_ONE;
            for (int i = 0; i < N_SUMS; i++) begin
                pow_sum[i] = fx_add(pow_sum[i], pw);
                if (i < N_COEF) wgt_sum[i] = fx_add(wgt_sum[i], fx_mul(pw, yq));
                pw = fx_mul(pw, xq);
            end
            set_points++;
        end
        if (!pr.final_point) return;
        sing = 1'b0;
        for (int r = 0; r < N_COEF; r++)
            for (int c = 0; c < N_COLS; c++)
                am[r][c] = (c < N_COEF) ? pow_sum[r + c] : ((c - N_COEF == r) ? Q_ONE : 64'sd0);
        // single upward neighbour-swap pass on the first column
        for (int r = N_COEF - 1; r > 0; r--) begin
            if (am[r-1][0] < am[r][0]) begin
                for (int c = 0; c < N_COLS; c++) begin
                    t = am[r][c];
                    am[r][c] = am[r-1][c];
                    am[r-1][c] = t;
                end
            end
        end
        for (int c = 0; c < N_COEF; c++) begin
            for (int r = 0; r < N_COEF; r++) begin
                if (r != c) begin
                    f = fx_div(am[r][c], am[c][c], sing);
                    for (int i = 0; i < N_COLS; i++)
                        am[r][i] = fx_sub(am[r][i], fx_mul(am[c][i], f));
                end
            end
        end
        for (int r = 0; r < N_COEF; r++) begin
            d = am[r][r];
            for (int c = 0; c < N_COLS; c++) am[r][c] = fx_div(am[r][c], d, sing);
        end
        for (int r = 0; r < N_COEF; r++) begin
            v = '0;
            for (int c = 0; c < N_COEF; c++)
                v = fx_add(v, fx_mul(am[r][c + N_COEF], wgt_sum[c]));
            res.coeff_index = r[2:0];
            res.coeff_value = v;
            res.singular    = sing;
            res.last_coeff  = (r == N_COEF - 1);
            coeff_fifo.push_back(res);
        end
        clear_fit_sums();
    endfunction

    // ---------------------------------------------------------------
    // Driver: after any drain, takes the next pending request once its gap has elapsed
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            s_valid <= 1'b0;
            s_data  <= '0;
            send_wait = 0;
        end else begin
            offer = s_valid;
            if (s_valid && s_ready) begin
                predict_fit(s_data);
                pairs_taken++;
                offer = 1'b0;
            end
            if (!offer && pair_fifo.size() > 0) begin
                if (pair_fifo[0].drain && coeff_fifo.size() > 0) begin
                    // hold the request until every coefficient has come back
                end else if (send_wait < pair_fifo[0].gap) begin
                    send_wait++;
                end else begin
                    nxt = pair_fifo.pop_front();
                    s_data <= nxt.pair;
                    offer = 1'b1;
                    send_wait = 0;
                end
            end
            s_valid <= offer;
        end
    end

    // ---------------------------------------------------------------
    // Long receiver hold-off: once, after at least 30 coefficients have been seen, m_ready is
    // kept low while the sender keeps offering pairs.
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        if (!aresetn) begin
            hold_left <= 0;
            hold_done <= 1'b0;
        end else if (hold_left > 0) begin
            hold_left <= hold_left - 1;
        end else if (!hold_done && m_valid && coeffs_seen >= 30) begin
            hold_left <= 1500;
            hold_done <= 1'b1;
        end
    end

    // ---------------------------------------------------------------
    // Monitor: random stalls, in-order compare against the coefficient queue
    // ---------------------------------------------------------------
    always @(posedge aclk) begin
        plsf_out_t want;
        if (!aresetn) begin
            m_ready <= 1'b0;
            recv_wait = 0;
        end else begin
            if (m_valid && m_ready) begin
                if (coeff_fifo.size() == 0) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected coefficient: idx %0d value %h sing %b last %b",
                                 m_data.coeff_index, m_data.coeff_value,
                                 m_data.singular, m_data.last_coeff);
                end else begin
                    want = coeff_fifo.pop_front();
                    if (m_data.coeff_index !== want.coeff_index ||
                        m_data.coeff_value !== want.coeff_value ||
                        m_data.singular !== want.singular ||
                        m_data.last_coeff !== want.last_coeff) begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"coeff mismatch: exp idx %0d val %h sing %b last %b,",
                                      " got idx %0d val %h sing %b last %b"},
                                     want.coeff_index, want.coeff_value, want.singular,
                                     want.last_coeff, m_data.coeff_index, m_data.coeff_value,
                                     m_data.singular, m_data.last_coeff);
                    end
                end
                coeffs_seen++;
                // every third block of 16 coefficients runs without stalls
                recv_wait = ((coeffs_seen / 16) % 3 == 0) ? 0 : $urandom_range(0, 8);
            end
            if (hold_left > 0) begin
                m_ready <= 1'b0;
            end else if (recv_wait > 0) begin
                recv_wait--;
                m_ready <= 1'b0;
            end else begin
                m_ready <= 1'b1;
            end
        end
    end

    // ---------------------------------------------------------------
    // Stimulus
    // ---------------------------------------------------------------
    function automatic void add_pair(input int x, input int y, input bit fin,
                                     input bit drain = 1'b0);
        pair_req_t p;
        p.pair.measured_sample = x[15:0];
        p.pair.expected_sample = y[15:0];
        p.pair.final_point     = fin;
        p.gap   = ((pairs_total / 32) % 3 == 0) ? 0 : $urandom_range(0, 8);
        p.drain = drain;
        pair_fifo.push_back(p);
        pairs_total++;
    endfunction

    function automatic int rand_sample(input bit narrow);
        if (narrow) return $urandom_range(0, 8191) - 4096;
        return $urandom_range(0, 65535) - 32768;
    endfunction

    initial begin
        int n_set;
        bit narrow;
        bit long_done;
        clear_fit_sums();
        long_done = 1'b0;
        // single-point set: rank deficient, zero pivots
        add_pair(8192, 4096, 1'b1);
        // field extremes
        add_pair(-32768, 32767, 1'b0);
        add_pair(32767, -32768, 1'b0);
        add_pair(0, 0, 1'b0);
        add_pair(1, -1, 1'b1);
        // identical abscissae: singular normal matrix
        add_pair(4096, 100, 1'b0);
        add_pair(4096, -100, 1'b0);
        add_pair(4096, 300, 1'b1);
        // well-spread set, exactly linear data
        add_pair(-16384, -8192, 1'b0);
        add_pair(-8192, 0, 1'b0);
        add_pair(0, 8192, 1'b0);
        add_pair(8192, 16384, 1'b0);
        add_pair(16384, 24576, 1'b1);
        // large values everywhere
        add_pair(-32768, -32768, 1'b0);
        add_pair(32767, 32767, 1'b0);
        add_pair(-32768, 32767, 1'b0);
        add_pair(32767, -32768, 1'b1);

        while (pairs_total < 420) begin
            if (!long_done && pairs_total > 150) begin
                // over-long set: pairs past the point cap are ignored
                for (int i = 0; i < 70; i++) add_pair(rand_sample(1'b1), rand_sample(1'b0),
                                                      i == 69);
                long_done = 1'b1;
            end else begin
                n_set  = ($urandom_range(0, 7) == 0) ? $urandom_range(1, 3)
                                                     : $urandom_range(4, 12);
                narrow = $urandom_range(0, 1);
                for (int i = 0; i < n_set; i++)
                    add_pair(rand_sample(narrow), rand_sample(narrow), i == n_set - 1,
                             (i == 0 && pairs_total > 300 && pairs_total < 315));
            end
        end
        add_pair(rand_sample(1'b0), rand_sample(1'b0), 1'b1);

        repeat (11) @(posedge aclk);
        aresetn <= 1'b1;

        while (pairs_taken < pairs_total || coeff_fifo.size() > 0) @(posedge aclk);
        repeat (200) @(posedge aclk);
        if (mismatches == 0) begin
            $display("CHECK OK");
        end else begin
            $display("CHECK FAILED");
        end
        $finish;
    end

    initial begin
        #200000000;
        $display("CHECK FAILED");
        $finish;
    end

endmodule

`default_nettype wire

FILE: filelist.f
rtl/plsf_pkg.sv
rtl/plsf_mul.sv
rtl/plsf_div.sv
rtl/plsf_datapath.sv
rtl/plsf_ctrl.sv
rtl/polynomial_least_squares_fit.sv
bench/testbench.sv
